/* rtl/core/l2ml_pkg.sv */
// Shared types and constants for the two-port MAC learning and rewrite core.
// Used by the entry lanes, the merge stage and the top level.
package l2ml_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int MAC_W         = 48;
  localparam int CFG_IDX_W     = 2;

  localparam logic [13:0] ETH_HDR_LEN = 14'd14;
  localparam logic [15:0] ETYPE_ARP   = 16'h0806;
  localparam logic [15:0] ETYPE_RARP  = 16'h8035;

  localparam logic [2:0] V_FORWARD = 3'd0;
  localparam logic [2:0] V_SHORT   = 3'd1;
  localparam logic [2:0] V_ARP     = 3'd2;
  localparam logic [2:0] V_SAME    = 3'd3;
  localparam logic [2:0] V_FULL    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PORT0_MAC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PORT1_MAC = CFG_IDX_W'(1);

  typedef struct packed {
    logic [MAC_W-1:0] dst_mac;
    logic [MAC_W-1:0] src_mac;
    logic [15:0]      eth_type;
    logic [13:0]      frame_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       verdict;
    logic             tx_port;
    logic             rx_port;
    logic [MAC_W-1:0] new_src_mac;
    logic [MAC_W-1:0] new_dst_mac;
  } out_item_t;

  // Write command for one table entry.
  typedef struct packed {
    logic             mac_we;
    logic             port_we;
    logic [MAC_W-1:0] mac;
    logic             port;
  } lane_wr_t;

  // Table update decided by the merge stage.
  typedef struct packed {
    logic [TABLE_ENTRIES-1:0] learn_src;
    logic [TABLE_ENTRIES-1:0] learn_dst;
    logic                     move_dst;
    logic                     ps;
    logic                     pd;
  } upd_t;

endpackage

/* rtl/core/l2_mac_learning_port_rewrite_core.sv */
// Top level of the two-port MAC learning and rewrite core.
// Depends on l2ml_pkg, l2ml_lane and l2ml_merge.
//
// Usage: one Ethernet header arrives per beat on the in_ channel (valid/ready). The core
// checks length, EtherType and equal addresses, looks both MACs up in a 64-entry
// learning table, learns new unicast addresses, and returns one result beat on the
// out_ channel with the verdict, the transmit and receive ports and the rewritten MACs.
// The cfg_ channel writes the port 0 and port 1 MAC registers; it is always ready and
// should only be used while no header is in flight.
// Each header passes through a lookup state, in which every table entry compares its
// stored MAC against both addresses in its own lane, and then a merge state, in which
// the merge stage picks free slots, updates the table and loads the output register.
// The next header is taken in that same merge state, so a result waiting in the output
// register does not block intake. If the receiver stalls, the core finishes looking up
// the next header and then holds in the merge state, without touching the table, until
// the output register is free.
// Reset clears the port MAC registers and all table valid bits, so the table is empty.
module l2_mac_learning_port_rewrite_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  l2ml_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output l2ml_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [l2ml_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [l2ml_pkg::MAC_W-1:0]        cfg_data
);
  import l2ml_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOK   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t                   state_r;
  state_t                   state_nxt;
  in_item_t                 item_r;
  out_item_t                out_data_r;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [MAC_W-1:0]         port0_mac_r;
  logic [MAC_W-1:0]         port1_mac_r;

  logic [TABLE_ENTRIES-1:0] src_hit;
  logic [TABLE_ENTRIES-1:0] dst_hit;
  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES-1:0] port_vec;
  out_item_t                result;
  upd_t                     upd;
  logic                     commit;
  logic                     in_fire;

  // The merge cycle commits only when the output register can take the result.
  assign commit    = (state_r == ST_DECIDE) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == ST_IDLE) || commit;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (commit) begin
          state_nxt = in_fire ? ST_LOOK : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      port0_mac_r <= '0;
      port1_mac_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_index == REG_PORT0_MAC) begin
        port0_mac_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_PORT1_MAC) begin
        port1_mac_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    if (commit) begin
      out_data_r <= result;
    end
  end

  // One lane per table entry; each lane owns its entry and its two comparators.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_lane
    lane_wr_t wr;

    always_comb begin
      wr.mac_we  = commit && (upd.learn_src[i] || upd.learn_dst[i]);
      wr.mac     = upd.learn_src[i] ? item_r.src_mac : item_r.dst_mac;
      wr.port_we = wr.mac_we || (commit && upd.move_dst && dst_hit[i]);
      wr.port    = upd.learn_src[i] ? upd.ps : upd.pd;
    end

    l2ml_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmp_en  (state_r == ST_LOOK),
      .src_mac (item_r.src_mac),
      .dst_mac (item_r.dst_mac),
      .wr      (wr),
      .src_hit (src_hit[i]),
      .dst_hit (dst_hit[i]),
      .valid   (valid_vec[i]),
      .port    (port_vec[i])
    );
  end

  l2ml_merge u_merge (
    .item      (item_r),
    .src_hit   (src_hit),
    .dst_hit   (dst_hit),
    .valid_vec (valid_vec),
    .port_vec  (port_vec),
    .port0_mac (port0_mac_r),
    .port1_mac (port1_mac_r),
    .result    (result),
    .upd       (upd)
  );

  // A learned address is held by exactly one entry, so lookups hit at most one lane.
  a_src_unique: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DECIDE |-> $onehot0(src_hit))
    else $error("source MAC matched more than one table entry");

  a_dst_unique: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DECIDE |-> $onehot0(dst_hit))
    else $error("destination MAC matched more than one table entry");

  // Learning writes distinct free entries only.
  a_learn_free: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> ($onehot0(upd.learn_src) && $onehot0(upd.learn_dst) &&
                ((upd.learn_src & upd.learn_dst) == '0) &&
                (((upd.learn_src | upd.learn_dst) & valid_vec) == '0)))
    else $error("learning targets a used or shared entry");

  // A committed result is presented on the next cycle.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed result not presented");

  // Dropped frames carry zero ports and addresses.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.verdict != V_FORWARD) |->
      (!out_data_r.tx_port && !out_data_r.rx_port &&
       out_data_r.new_src_mac == '0 && out_data_r.new_dst_mac == '0))
    else $error("dropped frame carries nonzero fields");

endmodule

/* rtl/core/l2ml_lane.sv */
// One table entry with its own comparators for the source and destination MAC.
// Depends on l2ml_pkg.
module l2ml_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmp_en,
  input  logic [l2ml_pkg::MAC_W-1:0] src_mac,
  input  logic [l2ml_pkg::MAC_W-1:0] dst_mac,
  input  l2ml_pkg::lane_wr_t     wr,
  output logic                   src_hit,
  output logic                   dst_hit,
  output logic                   valid,
  output logic                   port
);
  import l2ml_pkg::*;

  logic [MAC_W-1:0] mac_r;
  logic             port_r;
  logic             valid_r;
  logic             src_hit_r;
  logic             dst_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.mac_we) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.mac_we) begin
      mac_r <= wr.mac;
    end
    if (wr.port_we) begin
      port_r <= wr.port;
    end
    if (cmp_en) begin
      src_hit_r <= valid_r && (mac_r == src_mac);
      dst_hit_r <= valid_r && (mac_r == dst_mac);
    end
  end

  assign src_hit = src_hit_r;
  assign dst_hit = dst_hit_r;
  assign valid   = valid_r;
  assign port    = port_r;

endmodule

/* rtl/core/l2ml_merge.sv */
// Merge stage: combines the lane hit vectors into a verdict, ports, rewritten MACs
// and the table update. Depends on l2ml_pkg.
module l2ml_merge (
  input  l2ml_pkg::in_item_t                 item,
  input  logic [l2ml_pkg::TABLE_ENTRIES-1:0] src_hit,
  input  logic [l2ml_pkg::TABLE_ENTRIES-1:0] dst_hit,
  input  logic [l2ml_pkg::TABLE_ENTRIES-1:0] valid_vec,
  input  logic [l2ml_pkg::TABLE_ENTRIES-1:0] port_vec,
  input  logic [l2ml_pkg::MAC_W-1:0]         port0_mac,
  input  logic [l2ml_pkg::MAC_W-1:0]         port1_mac,
  output l2ml_pkg::out_item_t                result,
  output l2ml_pkg::upd_t                     upd
);
  import l2ml_pkg::*;

  function automatic logic [TABLE_ENTRIES-1:0] lowest_one(input logic [TABLE_ENTRIES-1:0] v);
    return v & (~v + TABLE_ENTRIES'(1));
  endfunction

  logic [TABLE_ENTRIES-1:0] free1;
  logic [TABLE_ENTRIES-1:0] free2;
  logic [TABLE_ENTRIES-1:0] slot1;
  logic [TABLE_ENTRIES-1:0] slot2;
  logic                     ns_hit;
  logic                     nd_hit;
  logic                     ps_tab;
  logic                     pd_tab;
  logic                     src_uni;
  logic                     dst_uni;
  logic [2:0]               verdict;
  logic                     ps;
  logic                     pd;
  logic [MAC_W-1:0]         nsrc;
  logic [MAC_W-1:0]         ndst;

  assign free1   = ~valid_vec;
  assign slot1   = lowest_one(free1);
  assign free2   = free1 & ~slot1;
  assign slot2   = lowest_one(free2);
  assign ns_hit  = |src_hit;
  assign nd_hit  = |dst_hit;
  assign ps_tab  = |(src_hit & port_vec);
  assign pd_tab  = |(dst_hit & port_vec);
  assign src_uni = !item.src_mac[40] && (item.src_mac != '0);
  assign dst_uni = !item.dst_mac[40] && (item.dst_mac != '0);

  always_comb begin
    verdict       = V_FORWARD;
    ps            = 1'b0;
    pd            = 1'b1;
    nsrc          = item.src_mac;
    ndst          = item.dst_mac;
    upd.learn_src = '0;
    upd.learn_dst = '0;
    upd.move_dst  = 1'b0;

    if (item.frame_length < ETH_HDR_LEN) begin
      verdict = V_SHORT;
    end else if (item.eth_type == ETYPE_ARP || item.eth_type == ETYPE_RARP) begin
      verdict = V_ARP;
    end else if (item.src_mac == item.dst_mac) begin
      verdict = V_SAME;
    end else if (ns_hit && nd_hit) begin
      ps           = ps_tab;
      pd           = (pd_tab == ps_tab) ? ~ps_tab : pd_tab;
      upd.move_dst = (pd_tab == ps_tab);
      nsrc         = ps ? port1_mac : port0_mac;
      ndst         = pd ? port1_mac : port0_mac;
    end else if (ns_hit) begin
      ps   = ps_tab;
      pd   = ~ps_tab;
      nsrc = ps ? port1_mac : port0_mac;
      if (dst_uni) begin
        ndst = pd ? port1_mac : port0_mac;
        if (|free1) begin
          upd.learn_dst = slot1;
        end else begin
          verdict = V_FULL;
        end
      end
    end else if (nd_hit) begin
      pd   = pd_tab;
      ps   = ~pd_tab;
      ndst = pd ? port1_mac : port0_mac;
      if (src_uni) begin
        nsrc = ps ? port1_mac : port0_mac;
        if (|free1) begin
          upd.learn_src = slot1;
        end else begin
          verdict = V_FULL;
        end
      end
    end else begin
      // Neither side known: source goes to port 0, destination to port 1.
      if (src_uni) begin
        if (|free1) begin
          upd.learn_src = slot1;
          nsrc          = port0_mac;
        end else begin
          verdict = V_FULL;
        end
      end
      if (verdict == V_FORWARD && dst_uni) begin
        if (src_uni ? (|free2) : (|free1)) begin
          upd.learn_dst = src_uni ? slot2 : slot1;
          ndst          = port1_mac;
        end else begin
          verdict = V_FULL;
        end
      end
    end

    upd.ps = ps;
    upd.pd = pd;

    result.verdict = verdict;
    if (verdict == V_FORWARD) begin
      result.tx_port     = ps;
      result.rx_port     = pd;
      result.new_src_mac = nsrc;
      result.new_dst_mac = ndst;
    end else begin
      result.tx_port     = 1'b0;
      result.rx_port     = 1'b0;
      result.new_src_mac = '0;
      result.new_dst_mac = '0;
    end
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the two-port MAC learning and rewrite core.
// Needs l2ml_pkg and the RTL of l2_mac_learning_port_rewrite_core; it reads no files.
// A directed table runs first, then four randomized phases checked against an in-bench model.
module testbench;
  import l2ml_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int ITEMS_PER_PHASE  = 112;
  localparam int PHASES           = 4;
  localparam int POOL_SIZE        = 80;
  localparam int LONG_HOLD_AT     = 260;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_TAIL       = 12;

  // Receiver behavior codes.
  localparam logic [1:0] RX_ALWAYS  = 2'd0;
  localparam logic [1:0] RX_RANDOM  = 2'd1;
  localparam logic [1:0] RX_PATTERN = 2'd2;

  // Addresses used by the directed table.
  localparam logic [MAC_W-1:0] MAC_A   = 48'h0200_0000_000A;
  localparam logic [MAC_W-1:0] MAC_B   = 48'h0200_0000_000B;
  localparam logic [MAC_W-1:0] MAC_C   = 48'h0200_0000_000C;
  localparam logic [MAC_W-1:0] MAC_D   = 48'h0200_0000_000D;
  localparam logic [MAC_W-1:0] MAC_E   = 48'h0200_0000_000E;
  localparam logic [MAC_W-1:0] MAC_F   = 48'hFEFF_FFFF_FFFF;
  localparam logic [MAC_W-1:0] BCAST   = 48'hFFFF_FFFF_FFFF;
  localparam logic [MAC_W-1:0] MCAST4  = 48'h0100_5E00_0001;
  localparam logic [MAC_W-1:0] MCAST6  = 48'h3333_0000_0001;
  localparam logic [MAC_W-1:0] NO_MAC  = 48'h0;
  localparam logic [MAC_W-1:0] DIR_P0  = 48'h0A0B_0C0D_0E0F;
  localparam logic [MAC_W-1:0] DIR_P1  = 48'h1A1B_1C1D_1E1F;

  typedef struct packed {
    bit        set_cfg;    // drain, then load DIR_P0/DIR_P1 before this beat
    in_item_t  hdr;
    bit        typed;      // want holds a result worked out by hand
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MAC_W-1:0]     cfg_data = '0;

  // Learning table as the testbench believes it to be, plus the port MAC registers.
  logic [MAC_W-1:0] learned_mac [TABLE_ENTRIES];
  logic             learned_port[TABLE_ENTRIES];
  bit               learned_used[TABLE_ENTRIES];
  logic [MAC_W-1:0] rewrite_mac [2];

  out_item_t expected_results[$];
  out_item_t head_result;
  logic [MAC_W-1:0] mac_pool[POOL_SIZE];

  int          failures = 0;
  int          accepted_headers = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          tx_bursty = 1'b1;
  logic [1:0]  rx_mode = RX_RANDOM;
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [31:0] rx_cycle = '0;

  always #2 clk = ~clk;

  l2_mac_learning_port_rewrite_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Model of the core. Lookups only hit valid entries and a new address takes
  // the lowest free slot, so an entry is never read before it was written.
  // ---------------------------------------------------------------------------
  function automatic bit is_unicast(input logic [MAC_W-1:0] mac);
    return !mac[40] && (mac != '0);
  endfunction

  function automatic int find_mac(input logic [MAC_W-1:0] mac);
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (learned_used[i] && learned_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  // Returns 0 when every slot is taken.
  function automatic bit take_slot(input logic [MAC_W-1:0] mac, input logic port);
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (!learned_used[i]) begin
        learned_used[i] = 1'b1;
        learned_mac[i]  = mac;
        learned_port[i] = port;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_item_t rewrite_header(input in_item_t hdr);
    out_item_t r;
    int        s_idx;
    int        d_idx;
    logic      ps;
    logic      pd;
    r.verdict     = V_FORWARD;
    r.new_src_mac = hdr.src_mac;
    r.new_dst_mac = hdr.dst_mac;
    ps = 1'b0;
    pd = 1'b1;
    // Length comes first, then the ARP/RARP filter, then the equal-address test.
    if (hdr.frame_length < ETH_HDR_LEN) begin
      r.verdict = V_SHORT;
    end else if (hdr.eth_type == ETYPE_ARP || hdr.eth_type == ETYPE_RARP) begin
      r.verdict = V_ARP;
    end else if (hdr.src_mac == hdr.dst_mac) begin
      r.verdict = V_SAME;
    end else begin
      s_idx = find_mac(hdr.src_mac);
      d_idx = find_mac(hdr.dst_mac);
      if (s_idx >= 0 && d_idx >= 0) begin
        // Both known: if they share a port, the destination moves over.
        ps = learned_port[s_idx];
        pd = learned_port[d_idx];
        if (pd == ps) begin
          pd = !ps;
          learned_port[d_idx] = pd;
        end
        r.new_src_mac = rewrite_mac[ps];
        r.new_dst_mac = rewrite_mac[pd];
      end else if (s_idx >= 0) begin
        ps = learned_port[s_idx];
        pd = !ps;
        if (is_unicast(hdr.dst_mac)) begin
          if (!take_slot(hdr.dst_mac, pd)) r.verdict = V_FULL;
          r.new_dst_mac = rewrite_mac[pd];
        end
        r.new_src_mac = rewrite_mac[ps];
      end else if (d_idx >= 0) begin
        pd = learned_port[d_idx];
        ps = !pd;
        if (is_unicast(hdr.src_mac)) begin
          if (!take_slot(hdr.src_mac, ps)) r.verdict = V_FULL;
          r.new_src_mac = rewrite_mac[ps];
        end
        r.new_dst_mac = rewrite_mac[pd];
      end else begin
        // Neither known: source starts on port 0. A source learned here stays
        // learned even when the destination then finds the table full.
        if (is_unicast(hdr.src_mac)) begin
          if (take_slot(hdr.src_mac, 1'b0)) r.new_src_mac = rewrite_mac[0];
          else r.verdict = V_FULL;
        end
        if (r.verdict == V_FORWARD && is_unicast(hdr.dst_mac)) begin
          if (take_slot(hdr.dst_mac, 1'b1)) r.new_dst_mac = rewrite_mac[1];
          else r.verdict = V_FULL;
        end
      end
    end
    // Dropped frames carry zero ports and zero addresses.
    if (r.verdict != V_FORWARD) begin
      ps = 1'b0;
      pd = 1'b0;
      r.new_src_mac = '0;
      r.new_dst_mac = '0;
    end
    r.tx_port = ps;
    r.rx_port = pd;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All tasks are entered right after a rising edge.
  // ---------------------------------------------------------------------------
  function automatic dir_row_t step_row(input bit set_cfg, input logic [MAC_W-1:0] dst,
                                        input logic [MAC_W-1:0] src, input logic [15:0] etype,
                                        input logic [13:0] len, input bit typed,
                                        input logic [2:0] verdict, input logic tx,
                                        input logic rx, input logic [MAC_W-1:0] nsrc,
                                        input logic [MAC_W-1:0] ndst);
    dir_row_t row;
    row.set_cfg           = set_cfg;
    row.hdr.dst_mac       = dst;
    row.hdr.src_mac       = src;
    row.hdr.eth_type      = etype;
    row.hdr.frame_length  = len;
    row.typed             = typed;
    row.want.verdict      = verdict;
    row.want.tx_port      = tx;
    row.want.rx_port      = rx;
    row.want.new_src_mac  = nsrc;
    row.want.new_dst_mac  = ndst;
    return row;
  endfunction

  // Mostly addresses from the pool, so lookups hit; the rest are the corner kinds.
  function automatic logic [MAC_W-1:0] pick_mac(input int span);
    int          roll;
    logic [31:0] hi;
    logic [31:0] lo;
    roll = $urandom_range(0, 99);
    hi   = $urandom;
    lo   = $urandom;
    if (roll < 84) return mac_pool[$urandom_range(0, span - 1)];
    if (roll < 88) return NO_MAC;
    if (roll < 91) return BCAST;
    if (roll < 95) return mac_pool[$urandom_range(0, span - 1)] | 48'h0100_0000_0000;
    return {hi[15:0], lo};
  endfunction

  // Offers one header beat. In bursty mode the sender drops valid between bursts.
  task automatic send_header(input in_item_t hdr, input bit typed, input out_item_t want);
    out_item_t predicted;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= hdr;
    do @(posedge clk); while (!in_ready);
    predicted = rewrite_header(hdr);
    expected_results.push_back(typed ? want : predicted);
    accepted_headers <= accepted_headers + 1;
  endtask

  // Stops offering headers and waits until every result beat is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Writes both port MAC registers back to back; valid stays high in between.
  task automatic set_port_macs(input logic [MAC_W-1:0] mac0, input logic [MAC_W-1:0] mac1);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PORT0_MAC;
    cfg_data  <= mac0;
    do @(posedge clk); while (!cfg_ready);
    rewrite_mac[0] = mac0;
    cfg_index <= REG_PORT1_MAC;
    cfg_data  <= mac1;
    do @(posedge clk); while (!cfg_ready);
    rewrite_mac[1] = mac1;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. It stalls according to rx_mode, and once, after enough headers
  // have gone in, it holds off for a long stretch so that the core backs up
  // and drops in_ready while the sender keeps offering.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_headers >= LONG_HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: begin
          out_ready <= 1'b1;
        end
        RX_PATTERN: begin
          out_ready <= rx_pattern[rx_cycle[3:0]];
        end
        default: begin
          out_ready <= ($urandom_range(0, 99) < 70);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result beat is matched against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [MAC_W-1:0] want,
                                      input logic [MAC_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no header pending: verdict %0h", out_data.verdict);
        failures++;
      end else begin
        head_result = expected_results.pop_front();
        check_field("verdict", MAC_W'(head_result.verdict), MAC_W'(out_data.verdict));
        check_field("tx_port", MAC_W'(head_result.tx_port), MAC_W'(out_data.tx_port));
        check_field("rx_port", MAC_W'(head_result.rx_port), MAC_W'(out_data.rx_port));
        check_field("new_src_mac", head_result.new_src_mac, out_data.new_src_mac);
        check_field("new_dst_mac", head_result.new_dst_mac, out_data.new_dst_mac);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t         plan[$];
    in_item_t         hdr;
    logic [MAC_W-1:0] ph_p0[PHASES];
    logic [MAC_W-1:0] ph_p1[PHASES];
    int               ph_span[PHASES];
    bit               ph_bursty[PHASES];
    logic [1:0]       ph_rx[PHASES];
    logic [31:0]      rnd_hi;
    logic [31:0]      rnd_lo;
    int               ph;
    int               n;
    int               roll;

    rewrite_mac[0] = '0;
    rewrite_mac[1] = '0;
    for (n = 0; n < POOL_SIZE; n++) begin
      rnd_hi = $urandom;
      rnd_lo = $urandom;
      mac_pool[n]     = {rnd_hi[15:0], rnd_lo};
      mac_pool[n][40] = 1'b0;
      mac_pool[n][0]  = 1'b1;   // never the all-zero address
    end

    // Phase settings: port MAC extremes and a random pair, a growing address
    // pool so the table fills up in the later phases, and varied flow control.
    ph_p0[0] = BCAST;  ph_p1[0] = NO_MAC;
    ph_p0[1] = NO_MAC; ph_p1[1] = BCAST;
    rnd_hi = $urandom; rnd_lo = $urandom; ph_p0[2] = {rnd_hi[15:0], rnd_lo};
    rnd_hi = $urandom; rnd_lo = $urandom; ph_p1[2] = {rnd_hi[15:0], rnd_lo};
    ph_p0[3] = BCAST;  ph_p1[3] = BCAST;
    ph_span   = '{24, 48, POOL_SIZE, POOL_SIZE};
    ph_bursty = '{1'b1, 1'b0, 1'b1, 1'b1};
    ph_rx     = '{RX_RANDOM, RX_ALWAYS, RX_PATTERN, RX_RANDOM};

    // Directed table. The first rows run on the reset values of the port MAC
    // registers; the rows that move entries between ports go to the model.
    plan.push_back(step_row(0, MAC_B, MAC_A, 16'h0800, 14'd0, 1,
                            V_SHORT, 0, 0, NO_MAC, NO_MAC));
    plan.push_back(step_row(0, MAC_B, MAC_A, ETYPE_ARP, 14'd13, 1,
                            V_SHORT, 0, 0, NO_MAC, NO_MAC));
    plan.push_back(step_row(0, MAC_B, MAC_A, ETYPE_ARP, 14'd14, 1,
                            V_ARP, 0, 0, NO_MAC, NO_MAC));
    plan.push_back(step_row(0, MAC_A, MAC_A, ETYPE_RARP, 14'h3FFF, 1,
                            V_ARP, 0, 0, NO_MAC, NO_MAC));
    plan.push_back(step_row(0, MAC_A, MAC_A, 16'h0800, 14'h3FFF, 1,
                            V_SAME, 0, 0, NO_MAC, NO_MAC));
    plan.push_back(step_row(0, MAC_B, MAC_A, 16'h0000, 14'd14, 1,
                            V_FORWARD, 0, 1, NO_MAC, NO_MAC));
    plan.push_back(step_row(1, MAC_B, MAC_A, 16'h0800, 14'd64, 1,
                            V_FORWARD, 0, 1, DIR_P0, DIR_P1));
    plan.push_back(step_row(0, MAC_A, MAC_B, 16'h86DD, 14'd1518, 1,
                            V_FORWARD, 1, 0, DIR_P1, DIR_P0));
    plan.push_back(step_row(0, MAC_C, MAC_A, 16'h0800, 14'd60, 1,
                            V_FORWARD, 0, 1, DIR_P0, DIR_P1));
    plan.push_back(step_row(0, MAC_A, MAC_D, 16'h0800, 14'd60, 1,
                            V_FORWARD, 1, 0, DIR_P1, DIR_P0));
    plan.push_back(step_row(0, BCAST, MAC_A, 16'h0800, 14'd60, 1,
                            V_FORWARD, 0, 1, DIR_P0, BCAST));
    plan.push_back(step_row(0, MAC_B, MCAST4, 16'h0800, 14'd60, 1,
                            V_FORWARD, 0, 1, MCAST4, DIR_P1));
    plan.push_back(step_row(0, MCAST6, NO_MAC, 16'h0800, 14'd60, 1,
                            V_FORWARD, 0, 1, NO_MAC, MCAST6));
    plan.push_back(step_row(0, NO_MAC, MAC_E, 16'h0800, 14'd60, 1,
                            V_FORWARD, 0, 1, DIR_P0, NO_MAC));
    plan.push_back(step_row(0, MAC_B, MAC_F, 16'hFFFF, 14'd60, 1,
                            V_FORWARD, 0, 1, DIR_P0, DIR_P1));
    plan.push_back(step_row(0, BCAST, BCAST, 16'hFFFF, 14'd14, 1,
                            V_SAME, 0, 0, NO_MAC, NO_MAC));
    // Both addresses on one port: the destination entry is moved each time.
    plan.push_back(step_row(0, MAC_D, MAC_C, 16'h0800, 14'd60, 0, '0, 0, 0, '0, '0));
    plan.push_back(step_row(0, MAC_A, MAC_D, 16'h8100, 14'd60, 0, '0, 0, 0, '0, '0));
    plan.push_back(step_row(0, MAC_B, MAC_A, 16'h0800, 14'd60, 0, '0, 0, 0, '0, '0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].set_cfg) begin
        drain_results();
        set_port_macs(DIR_P0, DIR_P1);
      end
      send_header(plan[i].hdr, plan[i].typed, plan[i].want);
    end

    // Random phases: mostly well-formed headers between pool addresses, with
    // a share of short, ARP/RARP and equal-address frames mixed in.
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      set_port_macs(ph_p0[ph], ph_p1[ph]);
      tx_bursty = ph_bursty[ph];
      rx_mode    <= ph_rx[ph];
      rx_pattern <= 16'($urandom) | 16'h0101;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        hdr.src_mac = pick_mac(ph_span[ph]);
        hdr.dst_mac = pick_mac(ph_span[ph]);
        case ($urandom_range(0, 3))
          0:       hdr.eth_type = 16'h0800;
          1:       hdr.eth_type = 16'h86DD;
          2:       hdr.eth_type = 16'h8100;
          default: hdr.eth_type = 16'($urandom_range(0, 65535));
        endcase
        if ($urandom_range(0, 9) == 0) hdr.frame_length = 14'($urandom_range(14, 16383));
        else hdr.frame_length = 14'($urandom_range(14, 1518));
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          hdr.frame_length = 14'($urandom_range(0, 13));
        end else if (roll < 12) begin
          hdr.eth_type = $urandom_range(0, 1) ? ETYPE_ARP : ETYPE_RARP;
        end else if (roll < 16) begin
          hdr.dst_mac = hdr.src_mac;
        end
        send_header(hdr, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
